// ===== hdl/sawtc_pkg.sv =====
// Shared types, codes and parameter defaults for the set-associative write-through cache.
`default_nettype none

package sawtc_pkg;

   localparam int SETS_DEFAULT       = 16;
   localparam int WAYS_DEFAULT       = 4;
   localparam int LINE_BYTES_DEFAULT = 32;
   localparam int ADDR_BITS_DEFAULT  = 32;
   localparam int WORD_BITS          = 64;
   localparam int RAM_DEPTH_DEFAULT  = 256;

   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_FILL  = 2'd2,
      CMD_INVAL = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_LOOKUP  = 5'b00010,
      ST_COMPARE = 5'b00100,
      ST_MODIFY  = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   // Fibonacci LFSR, taps 16, 14, 13, 11, shifting right
   function automatic logic [15:0] lfsr_next(input logic [15:0] s);
      logic fb;
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {fb, s[15:1]};
   endfunction

   // expand a byte mask to a bit mask
   function automatic logic [WORD_BITS-1:0] byte_to_bit_mask(input logic [7:0] m);
      logic [WORD_BITS-1:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = {8{m[i]}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sawtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sawtc_ram #(
   parameter int WIDTH = sawtc_pkg::WORD_BITS,
   parameter int DEPTH = sawtc_pkg::RAM_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/set_assoc_write_through_cache_top.sv =====
// Set-associative write-through cache with random replacement, top level.
//
// Input channel req_*: one beat carries a command (read, write, fill word,
// invalidate all), a byte address, an access length and a 64-bit payload.
// Result channel rsp_*: exactly one beat per input beat, in order.
// Tags sit in one RAM per way (one entry per set), line data in one RAM of
// 64-bit words; both have registered read data. A read or write walks tag
// read, compare, data read-modify-write; a miss ends after the compare, and
// a hit spanning two words passes the data step twice. Fill, invalidate and
// line-crossing reads end in the lookup step; a line-crossing write looks
// up both lines. The block takes one item at a time; req_stall is high
// while one is in work.
// The result register frees the pipe: the next item is accepted while a
// beat waits on rsp_stall; that item's result holds until the beat drains.
// Reset clears every valid bit, cancels a pending fill and seeds the LFSR.
// SETS, WAYS and LINE_BYTES are powers of two; LINE_BYTES is at least 8.
`default_nettype none

module set_assoc_write_through_cache_top #(
   parameter int SETS       = sawtc_pkg::SETS_DEFAULT,
   parameter int WAYS       = sawtc_pkg::WAYS_DEFAULT,
   parameter int LINE_BYTES = sawtc_pkg::LINE_BYTES_DEFAULT,
   parameter int ADDR_BITS  = sawtc_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_addr,
   input  wire logic [3:0]  req_access_bytes,
   input  wire logic [63:0] req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_hit,
   output logic [63:0]      rsp_load_data,
   output logic             rsp_fill_request,
   output logic [31:0]      rsp_fill_line_addr,
   output logic             rsp_uncached,
   output logic             rsp_write_through,
   output logic             rsp_fill_done
);

   localparam int EA    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int OFF_W = $clog2(LINE_BYTES);
   localparam int SET_W = $clog2(SETS);
   localparam int WPL   = LINE_BYTES / 8;
   localparam int WD_W  = (WPL > 1) ? $clog2(WPL) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int XW    = (EA > OFF_W + SET_W) ? EA : OFF_W + SET_W + 1;
   localparam int DW_W  = XW - 3;
   localparam int TAG_W = XW - OFF_W - SET_W;
   localparam int DEPTH = SETS * WAYS * WPL;
   localparam int DA_W  = $clog2(DEPTH);
   localparam bit WIDE_ADDR = (ADDR_BITS > 32);
   localparam logic [31:0]     EA_MASK   = 32'((64'd1 << EA) - 64'd1);
   localparam logic [DW_W-1:0] DW_MASK   = DW_W'((64'd1 << (EA - 3)) - 64'd1);
   localparam logic [31:0]     LINE_MASK = ~32'(LINE_BYTES - 1);

   function automatic logic [DA_W-1:0] word_addr(input logic [SET_W-1:0] s,
                                                 input logic [WAY_W-1:0] w,
                                                 input logic [WD_W-1:0] wd);
      return DA_W'((32'(s) * WAYS + 32'(w)) * WPL + 32'(wd));
   endfunction

   sawtc_pkg::state_type state_ff, state_in;
   sawtc_pkg::cmd_type   cmd_ff, cmd_in;
   logic [31:0]          addr_ff, addr_in;
   logic [3:0]           len_ff, len_in;
   logic [2:0]           bo_ff, bo_in;
   logic [63:0]          pay_ff, pay_in;
   logic                 two_ff, two_in;
   logic                 cross_ff, cross_in;
   logic [DW_W-1:0]      dw0_ff, dw0_in, dw1_ff, dw1_in;
   logic                 out1_ff, out1_in;
   logic                 op_ff, op_in;
   logic [DA_W-1:0]      data_addr_ff, data_addr_in;
   logic [1:0][63:0]     word_ff, word_in;
   logic                 res_hit_ff, res_hit_in;
   logic                 res_freq_ff, res_freq_in;
   logic                 res_unc_ff, res_unc_in;
   logic                 res_wt_ff, res_wt_in;
   logic                 res_fdone_ff, res_fdone_in;

   logic [SETS-1:0][WAYS-1:0] valid_ff, valid_in;
   logic                 fill_busy_ff, fill_busy_in;
   logic [SET_W-1:0]     fill_set_ff, fill_set_in;
   logic [WAY_W-1:0]     fill_way_ff, fill_way_in;
   logic [TAG_W-1:0]     fill_tag_ff, fill_tag_in;
   logic [WD_W-1:0]      fill_idx_ff, fill_idx_in;
   logic [15:0]          lfsr_ff, lfsr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [63:0]          rsp_load_data_ff, rsp_load_data_in;
   logic                 rsp_fill_request_ff, rsp_fill_request_in;
   logic [31:0]          rsp_fill_line_addr_ff, rsp_fill_line_addr_in;
   logic                 rsp_uncached_ff, rsp_uncached_in;
   logic                 rsp_write_through_ff, rsp_write_through_in;
   logic                 rsp_fill_done_ff, rsp_fill_done_in;

   // accept-side decode
   logic [31:0]      ea_c;
   logic [3:0]       len_c;
   logic [OFF_W-1:0] off_c;
   logic [DW_W:0]    dw_sum_c;

   // lookup of the current word
   logic [DW_W-1:0]  cur_dw;
   logic             cur_out;
   logic [SET_W-1:0] cur_set;
   logic [TAG_W-1:0] cur_tag;
   logic [WD_W-1:0]  cur_word;
   logic [WAYS-1:0][TAG_W-1:0] tag_q;
   logic [WAYS-1:0]  hit_vec;
   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] free_way;
   logic             free_any;

   // data path
   logic [127:0]     win_data;
   logic [15:0]      win_mask;
   logic [7:0]       len_mask;
   logic [63:0]      merge_mask;
   logic [127:0]     rd_window;
   logic             out_free;
   logic             tag_we;
   logic             data_we;
   logic [DA_W-1:0]  data_wr_addr;
   logic [63:0]      data_wr_data;
   logic [DA_W-1:0]  data_rd_addr;
   logic [63:0]      data_q;

   assign ea_c     = req_addr & EA_MASK;
   assign len_c    = (req_access_bytes == 4'd0) ? 4'd1 :
                     (req_access_bytes > 4'd8) ? 4'd8 : req_access_bytes;
   assign off_c    = OFF_W'(ea_c % LINE_BYTES);
   assign dw_sum_c = (DW_W + 1)'(DW_W'(ea_c >> 3)) + (DW_W + 1)'(1);

   assign cur_dw   = op_ff ? dw1_ff : dw0_ff;
   assign cur_out  = op_ff & out1_ff;
   assign cur_set  = cur_dw[OFF_W-3 +: SET_W];
   assign cur_tag  = cur_dw[DW_W-1 -: TAG_W];
   assign cur_word = WD_W'(cur_dw % WPL);

   assign len_mask   = 8'((9'd1 << len_ff) - 9'd1);
   assign win_data   = 128'(pay_ff) << {bo_ff, 3'b000};
   assign win_mask   = 16'(len_mask) << bo_ff;
   assign merge_mask = sawtc_pkg::byte_to_bit_mask(win_mask[op_ff*8 +: 8]);
   assign rd_window  = {word_ff[1], word_ff[0]} >> {bo_ff, 3'b000};
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      free_any = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = valid_ff[cur_set][w] && (tag_q[w] == cur_tag) && !cur_out;
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (!valid_ff[cur_set][w]) begin
            free_way = WAY_W'(w);
            free_any = 1'b1;
         end
      end
   end

   genvar gw;
   generate
      for (gw = 0; gw < WAYS; gw++) begin : g_tag
         sawtc_ram #(
            .WIDTH(TAG_W),
            .DEPTH(SETS)
         ) u_tag_ram (
            .clock  (clock),
            .wr_en  (tag_we && (fill_way_ff == WAY_W'(gw))),
            .wr_addr(fill_set_ff),
            .wr_data(fill_tag_ff),
            .rd_addr(cur_set),
            .rd_data(tag_q[gw])
         );
      end
   endgenerate

   sawtc_ram #(
      .WIDTH(64),
      .DEPTH(DEPTH)
   ) u_data_ram (
      .clock  (clock),
      .wr_en  (data_we),
      .wr_addr(data_wr_addr),
      .wr_data(data_wr_data),
      .rd_addr(data_rd_addr),
      .rd_data(data_q)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      bo_in        = bo_ff;
      pay_in       = pay_ff;
      two_in       = two_ff;
      cross_in     = cross_ff;
      dw0_in       = dw0_ff;
      dw1_in       = dw1_ff;
      out1_in      = out1_ff;
      op_in        = op_ff;
      data_addr_in = data_addr_ff;
      word_in      = word_ff;
      res_hit_in   = res_hit_ff;
      res_freq_in  = res_freq_ff;
      res_unc_in   = res_unc_ff;
      res_wt_in    = res_wt_ff;
      res_fdone_in = res_fdone_ff;
      valid_in     = valid_ff;
      fill_busy_in = fill_busy_ff;
      fill_set_in  = fill_set_ff;
      fill_way_in  = fill_way_ff;
      fill_tag_in  = fill_tag_ff;
      fill_idx_in  = fill_idx_ff;
      lfsr_in      = lfsr_ff;
      tag_we       = 1'b0;
      data_we      = 1'b0;
      data_wr_addr = data_addr_ff;
      data_wr_data = pay_ff;
      data_rd_addr = data_addr_ff;

      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      rsp_hit_in            = rsp_hit_ff;
      rsp_load_data_in      = rsp_load_data_ff;
      rsp_fill_request_in   = rsp_fill_request_ff;
      rsp_fill_line_addr_in = rsp_fill_line_addr_ff;
      rsp_uncached_in       = rsp_uncached_ff;
      rsp_write_through_in  = rsp_write_through_ff;
      rsp_fill_done_in      = rsp_fill_done_ff;

      unique case (state_ff)
         sawtc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = sawtc_pkg::cmd_type'(req_cmd);
               addr_in      = ea_c;
               len_in       = len_c;
               bo_in        = ea_c[2:0];
               pay_in       = req_payload;
               two_in       = ({1'b0, ea_c[2:0]} + len_c) > 4'd8;
               cross_in     = ((OFF_W + 2)'(off_c) + (OFF_W + 2)'(len_c))
                              > (OFF_W + 2)'(LINE_BYTES);
               dw0_in       = DW_W'(ea_c >> 3);
               dw1_in       = DW_W'(dw_sum_c) & DW_MASK;
               out1_in      = WIDE_ADDR && dw_sum_c[EA-3];
               op_in        = 1'b0;
               res_hit_in   = 1'b0;
               res_freq_in  = 1'b0;
               res_fdone_in = 1'b0;
               res_wt_in    = (sawtc_pkg::cmd_type'(req_cmd) == sawtc_pkg::CMD_WRITE);
               res_unc_in   = (((OFF_W + 2)'(off_c) + (OFF_W + 2)'(len_c))
                               > (OFF_W + 2)'(LINE_BYTES))
                              && ((sawtc_pkg::cmd_type'(req_cmd) == sawtc_pkg::CMD_READ)
                                 || (sawtc_pkg::cmd_type'(req_cmd) == sawtc_pkg::CMD_WRITE));
               state_in     = sawtc_pkg::ST_LOOKUP;
            end
         end
         sawtc_pkg::ST_LOOKUP: begin
            unique case (cmd_ff)
               sawtc_pkg::CMD_FILL: begin
                  if (fill_busy_ff) begin
                     data_we      = 1'b1;
                     data_wr_addr = word_addr(fill_set_ff, fill_way_ff, fill_idx_ff);
                     data_wr_data = pay_ff;
                     if (fill_idx_ff == WD_W'(WPL - 1)) begin
                        tag_we                            = 1'b1;
                        valid_in[fill_set_ff][fill_way_ff] = 1'b1;
                        fill_busy_in                      = 1'b0;
                        fill_idx_in                       = '0;
                        res_fdone_in                      = 1'b1;
                     end else begin
                        fill_idx_in = fill_idx_ff + WD_W'(1);
                     end
                  end
                  state_in = sawtc_pkg::ST_DONE;
               end
               sawtc_pkg::CMD_INVAL: begin
                  valid_in     = '0;
                  fill_busy_in = 1'b0;
                  fill_idx_in  = '0;
                  state_in     = sawtc_pkg::ST_DONE;
               end
               sawtc_pkg::CMD_READ: begin
                  state_in = cross_ff ? sawtc_pkg::ST_DONE : sawtc_pkg::ST_COMPARE;
               end
               sawtc_pkg::CMD_WRITE: begin
                  state_in = sawtc_pkg::ST_COMPARE;
               end
            endcase
         end
         sawtc_pkg::ST_COMPARE: begin
            if (|hit_vec) begin
               data_rd_addr = word_addr(cur_set, hit_way, cur_word);
               data_addr_in = word_addr(cur_set, hit_way, cur_word);
               if (!op_ff) begin
                  res_hit_in = !cross_ff;
               end
               state_in = sawtc_pkg::ST_MODIFY;
            end else if (cmd_ff == sawtc_pkg::CMD_READ) begin
               if (!fill_busy_ff) begin
                  if (free_any) begin
                     fill_way_in = free_way;
                  end else begin
                     fill_way_in = WAY_W'(lfsr_ff % WAYS);
                     lfsr_in     = sawtc_pkg::lfsr_next(lfsr_ff);
                  end
                  if (free_any) begin
                     valid_in[cur_set][free_way] = 1'b0;
                  end else begin
                     valid_in[cur_set][WAY_W'(lfsr_ff % WAYS)] = 1'b0;
                  end
                  fill_busy_in = 1'b1;
                  fill_set_in  = cur_set;
                  fill_tag_in  = cur_tag;
                  fill_idx_in  = '0;
                  res_freq_in  = 1'b1;
               end
               state_in = sawtc_pkg::ST_DONE;
            end else if (cross_ff && !op_ff) begin
               op_in    = 1'b1;
               state_in = sawtc_pkg::ST_LOOKUP;
            end else begin
               state_in = sawtc_pkg::ST_DONE;
            end
         end
         sawtc_pkg::ST_MODIFY: begin
            if (cmd_ff == sawtc_pkg::CMD_READ) begin
               word_in[op_ff] = data_q;
            end else begin
               data_we      = 1'b1;
               data_wr_addr = data_addr_ff;
               data_wr_data = (data_q & ~merge_mask) | (win_data[op_ff*64 +: 64] & merge_mask);
            end
            if (two_ff && !cross_ff && !op_ff) begin
               op_in        = 1'b1;
               data_rd_addr = data_addr_ff + DA_W'(1);
               data_addr_in = data_addr_ff + DA_W'(1);
            end else if (cross_ff && !op_ff) begin
               op_in    = 1'b1;
               state_in = sawtc_pkg::ST_LOOKUP;
            end else begin
               state_in = sawtc_pkg::ST_DONE;
            end
         end
         sawtc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_hit_in            = res_hit_ff;
               rsp_load_data_in      = (res_hit_ff && (cmd_ff == sawtc_pkg::CMD_READ))
                                       ? (rd_window[63:0]
                                          & sawtc_pkg::byte_to_bit_mask(len_mask))
                                       : 64'd0;
               rsp_fill_request_in   = res_freq_ff;
               rsp_fill_line_addr_in = res_freq_ff ? (addr_ff & LINE_MASK) : 32'd0;
               rsp_uncached_in       = res_unc_ff;
               rsp_write_through_in  = res_wt_ff;
               rsp_fill_done_in      = res_fdone_ff;
               state_in              = sawtc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sawtc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sawtc_pkg::ST_IDLE;
         valid_ff     <= '0;
         fill_busy_ff <= 1'b0;
         fill_idx_ff  <= '0;
         lfsr_ff      <= sawtc_pkg::LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fill_busy_ff <= fill_busy_in;
         fill_idx_ff  <= fill_idx_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff                <= cmd_in;
      addr_ff               <= addr_in;
      len_ff                <= len_in;
      bo_ff                 <= bo_in;
      pay_ff                <= pay_in;
      two_ff                <= two_in;
      cross_ff              <= cross_in;
      dw0_ff                <= dw0_in;
      dw1_ff                <= dw1_in;
      out1_ff               <= out1_in;
      op_ff                 <= op_in;
      data_addr_ff          <= data_addr_in;
      word_ff               <= word_in;
      res_hit_ff            <= res_hit_in;
      res_freq_ff           <= res_freq_in;
      res_unc_ff            <= res_unc_in;
      res_wt_ff             <= res_wt_in;
      res_fdone_ff          <= res_fdone_in;
      fill_set_ff           <= fill_set_in;
      fill_way_ff           <= fill_way_in;
      fill_tag_ff           <= fill_tag_in;
      rsp_hit_ff            <= rsp_hit_in;
      rsp_load_data_ff      <= rsp_load_data_in;
      rsp_fill_request_ff   <= rsp_fill_request_in;
      rsp_fill_line_addr_ff <= rsp_fill_line_addr_in;
      rsp_uncached_ff       <= rsp_uncached_in;
      rsp_write_through_ff  <= rsp_write_through_in;
      rsp_fill_done_ff      <= rsp_fill_done_in;
   end

   assign req_stall          = (state_ff != sawtc_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_load_data      = rsp_load_data_ff;
   assign rsp_fill_request   = rsp_fill_request_ff;
   assign rsp_fill_line_addr = rsp_fill_line_addr_ff;
   assign rsp_uncached       = rsp_uncached_ff;
   assign rsp_write_through  = rsp_write_through_ff;
   assign rsp_fill_done      = rsp_fill_done_ff;

   a_fill_line_invalid: assert property (@(posedge clock) disable iff (reset)
      fill_busy_ff |-> !valid_ff[fill_set_ff][fill_way_ff])
      else $error("line under fill is marked valid");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sawtc_pkg::ST_COMPARE) |-> $onehot0(hit_vec))
      else $error("more than one way hits");

   a_fill_index_idle: assert property (@(posedge clock) disable iff (reset)
      !fill_busy_ff |-> (fill_idx_ff == '0))
      else $error("fill word index nonzero with no fill pending");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sawtc_pkg::ST_DONE) && out_free)
      |=> (rsp_valid_ff && (state_ff == sawtc_pkg::ST_IDLE)))
      else $error("finished result not loaded into the output register");

   a_modify_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sawtc_pkg::ST_MODIFY)
      |-> (($past(state_ff) == sawtc_pkg::ST_COMPARE)
           || ($past(state_ff) == sawtc_pkg::ST_MODIFY)))
      else $error("data update without a preceding tag compare");

endmodule

`default_nettype wire
